/* src/psms_pkg.sv */
`timescale 1ns / 1ps

package psms_pkg;

  // capacity and derived widths
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned WW    = AW + 1;
  localparam int unsigned SW    = AW + 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 11;

  // request codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic                    func;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic                    is_odd;
    logic [CNT_W-1:0]        even_count;
    logic [CNT_W-1:0]        odd_count;
    logic                    final_item;
    logic                    none_left;
    logic                    overflowed;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_start;
    logic rd_done;
    logic sort_init;
    logic part_rd;
    logic part_wr;
    logic seg_start;
    logic next_run;
    logic next_seg;
    logic next_pass;
    logic run_init;
    logic cap_a0;
    logic cap_b0;
    logic emit;
    logic cap_a;
    logic cap_b;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic total_zero;
    logic part_last;
    logic need_pass;
    logic seg_empty;
    logic seg_odd;
    logic run_last;
    logic b_run;
    logic heads_empty;
    logic take_a;
    logic a_more;
    logic b_more;
    logic out_busy;
  } sts_t;

endpackage

/* src/psms_ram.sv */
`timescale 1ns / 1ps

module psms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/psms_datapath.sv */
`timescale 1ns / 1ps

module psms_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psms_pkg::in_item_t  in_data_i,
  input  psms_pkg::cmd_t      cmd_i,
  output psms_pkg::sts_t      sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output psms_pkg::out_item_t out_data_o
);

  import psms_pkg::*;

  // set bookkeeping
  logic [CW-1:0] even_q, even_d, odd_q, odd_d, rp_q, rp_d;
  logic          closed_q, closed_d, drop_q, drop_d;
  logic          out_valid_q, out_valid_d, src_b_q, src_b_d;
  out_item_t     out_q, out_d;

  // sort pointers and merge heads
  logic [CW-1:0]           i_q, i_d, ep_q, ep_d, op_q, op_d;
  logic [WW-1:0]           w_q, w_d;
  logic                    seg_q, seg_d;
  logic [SW-1:0]           lo_q, lo_d, a_q, a_d, b_q, b_d, k_q, k_d;
  logic [SW-1:0]           mid_q, mid_d, hi_q, hi_d;
  logic signed [VAL_W-1:0] ha_q, ha_d, hb_q, hb_d;
  logic                    va_q, va_d, vb_q, vb_d;

  // memory ports
  logic             we0, we1;
  logic [AW-1:0]    waddr0, waddr1, raddr;
  logic [VAL_W-1:0] wdata0, wdata1, rdata0, rdata1, rd_src;

  // derived values
  logic [SW-1:0]           total_s, seg_base, seg_end, w_s, lo_w, lo_2w, mid_n, hi_n;
  logic [SW-1:0]           a_next, b_next, ld_total;
  logic [CW-1:0]           max_grp, ld_e, ld_o, part_ptr;
  logic                    take_a, ld_fit, rd_hit;
  logic signed [VAL_W-1:0] emit_val;

  assign total_s  = SW'(even_q) + SW'(odd_q);
  assign seg_base = seg_q ? SW'(even_q) : '0;
  assign seg_end  = seg_q ? total_s : SW'(even_q);
  assign w_s      = SW'(w_q);
  assign lo_w     = lo_q + w_s;
  assign lo_2w    = lo_q + (w_s << 1);
  assign mid_n    = (lo_w < seg_end) ? lo_w : seg_end;
  assign hi_n     = (lo_2w < seg_end) ? lo_2w : seg_end;
  assign max_grp  = (even_q > odd_q) ? even_q : odd_q;
  assign a_next   = a_q + 1'b1;
  assign b_next   = b_q + 1'b1;
  assign rd_src   = src_b_q ? rdata1 : rdata0;

  // stable merge: the left run wins ties
  assign take_a   = va_q && (!vb_q || (ha_q <= hb_q));
  assign emit_val = take_a ? ha_q : hb_q;

  // a load after close opens a new set
  assign ld_e     = closed_q ? '0 : even_q;
  assign ld_o     = closed_q ? '0 : odd_q;
  assign ld_total = SW'(ld_e) + SW'(ld_o);
  assign ld_fit   = ld_total < SW'(DEPTH);

  assign part_ptr = rdata0[0] ? op_q : ep_q;
  assign rd_hit   = closed_q && (SW'(rp_q) < total_s);

  // status
  assign sts_o.total_zero  = (total_s == '0);
  assign sts_o.part_last   = (SW'(i_q) + 1'b1) >= total_s;
  assign sts_o.need_pass   = w_s < SW'(max_grp);
  assign sts_o.seg_empty   = seg_base >= seg_end;
  assign sts_o.seg_odd     = seg_q;
  assign sts_o.run_last    = lo_2w >= seg_end;
  assign sts_o.b_run       = b_q < hi_q;
  assign sts_o.heads_empty = !va_q && !vb_q;
  assign sts_o.take_a      = take_a;
  assign sts_o.a_more      = a_next < mid_q;
  assign sts_o.b_more      = b_next < hi_q;
  assign sts_o.out_busy    = out_valid_q && out_stall_i;

  // shared read address for both buffers
  always_comb begin
    raddr = '0;
    if (cmd_i.part_rd) begin
      raddr = i_q[AW-1:0];
    end else if (cmd_i.rd_start) begin
      raddr = rp_q[AW-1:0];
    end else if (cmd_i.run_init) begin
      raddr = lo_q[AW-1:0];
    end else if (cmd_i.cap_a0) begin
      raddr = b_q[AW-1:0];
    end else if (cmd_i.emit) begin
      raddr = take_a ? a_next[AW-1:0] : b_next[AW-1:0];
    end
  end

  // buffer a takes loads, buffer b the partition, merges ping-pong
  assign we0    = (cmd_i.load && ld_fit) || (cmd_i.emit && src_b_q);
  assign waddr0 = cmd_i.load ? ld_total[AW-1:0] : k_q[AW-1:0];
  assign wdata0 = cmd_i.load ? in_data_i.value : emit_val;
  assign we1    = cmd_i.part_wr || (cmd_i.emit && !src_b_q);
  assign waddr1 = cmd_i.part_wr ? part_ptr[AW-1:0] : k_q[AW-1:0];
  assign wdata1 = cmd_i.part_wr ? rdata0 : emit_val;

  psms_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_buf_a (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr0),
    .wdata_i (wdata0),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  psms_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_buf_b (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr1),
    .wdata_i (wdata1),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  // next state
  always_comb begin
    even_d      = even_q;
    odd_d       = odd_q;
    rp_d        = rp_q;
    closed_d    = closed_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    src_b_d     = src_b_q;
    out_d       = out_q;
    i_d         = i_q;
    ep_d        = ep_q;
    op_d        = op_q;
    w_d         = w_q;
    seg_d       = seg_q;
    lo_d        = lo_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    ha_d        = ha_q;
    hb_d        = hb_q;
    va_d        = va_q;
    vb_d        = vb_q;

    // output register drains on transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      closed_d = 1'b0;
      rp_d     = closed_q ? '0 : rp_q;
      drop_d   = closed_q ? 1'b0 : drop_q;
      even_d   = ld_e;
      odd_d    = ld_o;
      if (!ld_fit) begin
        drop_d = 1'b1;
      end else if (in_data_i.value[0]) begin
        odd_d = ld_o + 1'b1;
      end else begin
        even_d = ld_e + 1'b1;
      end
    end

    if (cmd_i.rd_done) begin
      out_d.value_res  = rd_hit ? rd_src : '0;
      out_d.is_odd     = rd_hit && (rp_q >= even_q);
      out_d.even_count = CNT_W'(even_q);
      out_d.odd_count  = CNT_W'(odd_q);
      out_d.final_item = rd_hit && ((SW'(rp_q) + 1'b1) == total_s);
      out_d.none_left  = !rd_hit;
      out_d.overflowed = drop_q;
      out_valid_d      = 1'b1;
      if (rd_hit) begin
        rp_d = rp_q + 1'b1;
      end
    end

    if (cmd_i.sort_init) begin
      i_d     = '0;
      ep_d    = '0;
      op_d    = even_q;
      w_d     = WW'(1);
      src_b_d = 1'b1;
      seg_d   = 1'b0;
    end

    if (cmd_i.part_wr) begin
      i_d = i_q + 1'b1;
      if (rdata0[0]) begin
        op_d = op_q + 1'b1;
      end else begin
        ep_d = ep_q + 1'b1;
      end
    end

    if (cmd_i.seg_start) begin
      lo_d = seg_base;
    end
    if (cmd_i.next_run) begin
      lo_d = lo_2w;
    end
    if (cmd_i.next_seg) begin
      seg_d = 1'b1;
    end
    if (cmd_i.next_pass) begin
      w_d     = w_q << 1;
      src_b_d = !src_b_q;
      seg_d   = 1'b0;
    end

    if (cmd_i.run_init) begin
      a_d   = lo_q;
      b_d   = mid_n;
      k_d   = lo_q;
      mid_d = mid_n;
      hi_d  = hi_n;
    end

    if (cmd_i.cap_a0) begin
      ha_d = rd_src;
      va_d = 1'b1;
      vb_d = 1'b0;
    end
    if (cmd_i.cap_b0) begin
      hb_d = rd_src;
      vb_d = 1'b1;
    end

    if (cmd_i.emit) begin
      k_d = k_q + 1'b1;
      if (take_a) begin
        a_d  = a_next;
        va_d = sts_o.a_more;
      end else begin
        b_d  = b_next;
        vb_d = sts_o.b_more;
      end
    end

    if (cmd_i.cap_a) begin
      ha_d = rd_src;
    end
    if (cmd_i.cap_b) begin
      hb_d = rd_src;
    end

    if (cmd_i.finish) begin
      closed_d = 1'b1;
      rp_d     = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_q      <= '0;
      odd_q       <= '0;
      rp_q        <= '0;
      closed_q    <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      src_b_q     <= 1'b0;
      seg_q       <= 1'b0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
    end else begin
      even_q      <= even_d;
      odd_q       <= odd_d;
      rp_q        <= rp_d;
      closed_q    <= closed_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      src_b_q     <= src_b_d;
      seg_q       <= seg_d;
      va_q        <= va_d;
      vb_q        <= vb_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    i_q   <= i_d;
    ep_q  <= ep_d;
    op_q  <= op_d;
    w_q   <= w_d;
    lo_q  <= lo_d;
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    ha_q  <= ha_d;
    hb_q  <= hb_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // read result only lands in an empty output register
  a_rd_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_done |-> !out_valid_q)
    else $error("read result overwrites pending output");

  // merge write pointer tracks both run pointers
  a_merge_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (k_q == a_q + b_q - mid_q))
    else $error("merge write pointer out of step");

  // partition ends with each pointer at its group boundary
  a_part_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.part_wr && sts_o.part_last) |=> ((ep_q == even_q) && (SW'(op_q) == total_s)))
    else $error("partition pointers miss group boundaries");

endmodule

/* src/psms_ctrl.sv */
`timescale 1ns / 1ps

module psms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_func_i,
  input  logic           in_last_i,
  output logic           in_stall_o,
  output psms_pkg::cmd_t cmd_o,
  input  psms_pkg::sts_t sts_i
);

  import psms_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDW    = 4'd1;
  localparam logic [3:0] S_PSTART = 4'd2;
  localparam logic [3:0] S_PRD    = 4'd3;
  localparam logic [3:0] S_PWR    = 4'd4;
  localparam logic [3:0] S_PASS   = 4'd5;
  localparam logic [3:0] S_SEG    = 4'd6;
  localparam logic [3:0] S_INIT   = 4'd7;
  localparam logic [3:0] S_CAPA0  = 4'd8;
  localparam logic [3:0] S_CAPB0  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_CAPA   = 4'd11;
  localparam logic [3:0] S_CAPB   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       accept;

  // reads wait for a free output register, loads do not
  assign in_stall_o = (state_q != S_IDLE) || ((in_func_i == FUNC_READ) && sts_i.out_busy);
  assign accept     = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_READ) begin
            cmd_o.rd_start = 1'b1;
            state_d        = S_RDW;
          end else begin
            cmd_o.load = 1'b1;
            if (in_last_i) begin
              state_d = S_PSTART;
            end
          end
        end
      end
      S_RDW: begin
        cmd_o.rd_done = 1'b1;
        state_d       = S_IDLE;
      end
      S_PSTART: begin
        cmd_o.sort_init = 1'b1;
        state_d         = sts_i.total_zero ? S_DONE : S_PRD;
      end
      S_PRD: begin
        cmd_o.part_rd = 1'b1;
        state_d       = S_PWR;
      end
      S_PWR: begin
        cmd_o.part_wr = 1'b1;
        state_d       = sts_i.part_last ? S_PASS : S_PRD;
      end
      S_PASS: begin
        state_d = sts_i.need_pass ? S_SEG : S_DONE;
      end
      S_SEG: begin
        if (!sts_i.seg_empty) begin
          cmd_o.seg_start = 1'b1;
          state_d         = S_INIT;
        end else if (sts_i.seg_odd) begin
          cmd_o.next_pass = 1'b1;
          state_d         = S_PASS;
        end else begin
          cmd_o.next_seg = 1'b1;
        end
      end
      S_INIT: begin
        cmd_o.run_init = 1'b1;
        state_d        = S_CAPA0;
      end
      S_CAPA0: begin
        cmd_o.cap_a0 = 1'b1;
        state_d      = sts_i.b_run ? S_CAPB0 : S_OUT;
      end
      S_CAPB0: begin
        cmd_o.cap_b0 = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.heads_empty) begin
          cmd_o.emit = 1'b1;
          if (sts_i.take_a) begin
            state_d = sts_i.a_more ? S_CAPA : S_OUT;
          end else begin
            state_d = sts_i.b_more ? S_CAPB : S_OUT;
          end
        end else if (!sts_i.run_last) begin
          cmd_o.next_run = 1'b1;
          state_d        = S_INIT;
        end else if (sts_i.seg_odd) begin
          cmd_o.next_pass = 1'b1;
          state_d         = S_PASS;
        end else begin
          cmd_o.next_seg = 1'b1;
          state_d        = S_SEG;
        end
      end
      S_CAPA: begin
        cmd_o.cap_a = 1'b1;
        state_d     = S_OUT;
      end
      S_CAPB: begin
        cmd_o.cap_b = 1'b1;
        state_d     = S_OUT;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // nothing is taken while a sort or a read is under way
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

  // a read always finishes in the following cycle
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_start |=> cmd_o.rd_done)
    else $error("read did not complete");

endmodule

/* src/parity_split_merge_sorter.sv */
`timescale 1ns / 1ps
// load: a load that is not the closing one leaves the input free for the next transfer; read: the result
// passes the read state and the output register, and the input stalls until the read has finished
// closing load: starts the sort, which splits the values into even and odd groups and then merges
// each group in passes of doubling run width until the width reaches the larger group, the merge
// loop being limited by the single read port of the source buffer
// reset: counts, flags, read position and sequencer cleared; buffers are not cleared

module parity_split_merge_sorter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psms_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psms_pkg::out_item_t out_data_o
);

  import psms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  psms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // buffers, pointers and result register
  psms_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
